>>> sv/bbc_pkg.sv
// shared types and constants of the block buffer cache tag table
// no dependencies; imported by every module of the block
`default_nettype none

package bbc_pkg;

    // table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    // beat widths
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 56;

    // item kinds
    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_FREE     = 2'd1;
    localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

    localparam logic [7:0] REF_MAX = 8'hFF;

    // one table entry as stored in the memory
    typedef struct packed {
        logic [7:0]  tag_device;
        logic [31:0] tag_block;
        logic [7:0]  ref_count;
        logic [31:0] last_use;
    } entry_t;

    // result fields, last field in the lowest bits
    typedef struct packed {
        logic [31:0] out_block;
        logic [7:0]  out_device;
        logic        needs_writeback;
        logic        needs_fetch;
        logic [5:0]  slot;
        logic [1:0]  status;
    } result_t;

    // table port requests from the sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } tbl_req_t;

    // compare unit verdict for one entry
    typedef struct packed {
        logic hit;
        logic better;
    } cmp_res_t;

endpackage

`default_nettype wire

>>> sv/bbc_table.sv
// tag table memory with per-entry occupied bits and a registered read port
// depends on bbc_pkg
`default_nettype none

module bbc_table
    import bbc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire tbl_req_t req,
    input  wire entry_t   wr_data,
    output logic          rd_occ,
    output entry_t        rd_entry
);

    entry_t              mem [ENTRIES];
    logic [ENTRIES-1:0]  occ_reg;
    entry_t              rd_data_reg;
    logic                rd_occ_reg;

    // every write lands on an entry that is or becomes occupied
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                occ_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_occ_reg <= occ_reg[req.rd_addr];
            end
        end
    end

    // a never-written entry reads as all zero
    assign rd_occ   = rd_occ_reg;
    assign rd_entry = rd_occ_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> sv/bbc_cmp.sv
// shared compare unit: tag match and oldest-unreferenced test for one entry
// depends on bbc_pkg
`default_nettype none

module bbc_cmp
    import bbc_pkg::*;
(
    input  wire logic        occ,
    input  wire entry_t      entry,
    input  wire logic [7:0]  key_device,
    input  wire logic [31:0] key_block,
    input  wire logic        have_best,
    input  wire logic [31:0] best_stamp,
    output cmp_res_t         res
);

    always_comb begin
        res.hit    = occ && (entry.tag_device == key_device) &&
                     (entry.tag_block == key_block);
        // strict less keeps the lowest index on equal stamps
        res.better = (entry.ref_count == 8'd0) &&
                     (!have_best || (entry.last_use < best_stamp));
    end

endmodule

`default_nettype wire

>>> sv/block_buffer_cache_lru_top.sv
// acquire: a miss scans every one of the ENTRIES table entries before the result beat, and a hit on entry i
//   ends the scan there; one table entry is read per cycle through one read port
// release: one table read, then one write unless the count is already zero
// one item at a time; s_tready is high only while idle
// reset (aresetn low, synchronous) empties the table: all entries read as zero
// depends on bbc_pkg, bbc_table, bbc_cmp
`default_nettype none

module block_buffer_cache_lru_top
    import bbc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // device[7:0], block_number[39:8], entry_index[45:40], current_tick[77:46], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // kind[0]
    input  wire logic                s_tuser,
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[1:0], slot[7:2], needs_fetch[8], needs_writeback[9],
    // out_device[17:10], out_block[49:18], zero pad
    output logic [M_DATA_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REL_RD,
        S_REL_EV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // latched item
    logic        kind_reg, kind_next;
    logic [7:0]  dev_reg, dev_next;
    logic [31:0] blk_reg, blk_next;
    logic [5:0]  idx_reg, idx_next;
    logic [31:0] tick_reg, tick_next;

    // scan bookkeeping
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             have_vic_reg, have_vic_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [31:0]      vic_stamp_reg, vic_stamp_next;

    // pending table update and result
    logic             wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0] wr_addr_reg, wr_addr_next;
    entry_t           wr_data_reg, wr_data_next;
    result_t          res_reg, res_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    result_t          m_res_reg, m_res_next;

    tbl_req_t tbl_req;
    logic     rd_occ;
    entry_t   rd_entry;
    cmp_res_t cmp;
    logic     issuing;
    logic     out_free;
    logic     beyond;

    bbc_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (tbl_req),
        .wr_data  (wr_data_reg),
        .rd_occ   (rd_occ),
        .rd_entry (rd_entry)
    );

    bbc_cmp u_cmp (
        .occ        (rd_occ),
        .entry      (rd_entry),
        .key_device (dev_reg),
        .key_block  (blk_reg),
        .have_best  (have_vic_reg),
        .best_stamp (vic_stamp_reg),
        .res        (cmp)
    );

    // scan issues one read per cycle until every entry is requested or a hit ends the scan
    assign issuing  = (state_reg == S_SCAN) && (issue_cnt_reg < CNT_W'(ENTRIES));
    assign out_free = !m_valid_reg || m_tready;
    assign beyond   = 32'(s_tdata[45:40]) >= 32'(ENTRIES);

    always_comb begin
        tbl_req.rd_en   = issuing || (state_reg == S_REL_RD);
        tbl_req.rd_addr = issuing ? issue_cnt_reg[IDX_W-1:0] : IDX_W'(idx_reg);
        // the table changes only as the result is handed to the output register
        tbl_req.wr_en   = (state_reg == S_DONE) && out_free && wr_pend_reg;
        tbl_req.wr_addr = wr_addr_reg;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, m_res_reg};

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        dev_next       = dev_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        tick_next      = tick_reg;
        issue_cnt_next = issue_cnt_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        have_vic_next  = have_vic_reg;
        vic_idx_next   = vic_idx_reg;
        vic_stamp_next = vic_stamp_reg;
        wr_pend_next   = wr_pend_reg;
        wr_addr_next   = wr_addr_reg;
        wr_data_next   = wr_data_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_res_next     = m_res_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next      = s_tuser;
                    dev_next       = s_tdata[7:0];
                    blk_next       = s_tdata[39:8];
                    idx_next       = s_tdata[45:40];
                    tick_next      = s_tdata[77:46];
                    issue_cnt_next = '0;
                    cmp_valid_next = 1'b0;
                    have_vic_next  = 1'b0;
                    wr_pend_next   = 1'b0;
                    if (s_tuser == KIND_RELEASE) begin
                        if (beyond) begin
                            // release past the table end: nothing to read
                            res_next        = '0;
                            res_next.status = ST_BAD_RELEASE;
                            res_next.slot   = s_tdata[45:40];
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_REL_RD;
                        end
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                cmp_valid_next = issuing;
                cmp_idx_next   = tbl_req.rd_addr;
                if (issuing) begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (cmp_valid_reg && cmp.hit) begin
                    // hit: bump count with saturation, restamp
                    wr_data_next           = rd_entry;
                    wr_data_next.ref_count = (rd_entry.ref_count == REF_MAX) ?
                                             REF_MAX : rd_entry.ref_count + 8'd1;
                    wr_data_next.last_use  = tick_reg;
                    wr_addr_next           = cmp_idx_reg;
                    wr_pend_next           = 1'b1;
                    // an occupied entry always holds valid data
                    res_next.status          = ST_OK;
                    res_next.slot            = 6'(cmp_idx_reg);
                    res_next.needs_fetch     = 1'b0;
                    res_next.needs_writeback = 1'b0;
                    res_next.out_device      = dev_reg;
                    res_next.out_block       = blk_reg;
                    state_next               = S_DONE;
                end else if (cmp_valid_reg) begin
                    if (cmp.better) begin
                        have_vic_next  = 1'b1;
                        vic_idx_next   = cmp_idx_reg;
                        vic_stamp_next = rd_entry.last_use;
                    end
                end else if (!issuing) begin
                    // every entry compared, no hit
                    if (have_vic_reg) begin
                        wr_data_next.tag_device  = dev_reg;
                        wr_data_next.tag_block   = blk_reg;
                        wr_data_next.ref_count   = 8'd1;
                        wr_data_next.last_use    = tick_reg;
                        wr_addr_next             = vic_idx_reg;
                        wr_pend_next             = 1'b1;
                        res_next.status          = ST_OK;
                        res_next.slot            = 6'(vic_idx_reg);
                        res_next.needs_fetch     = 1'b1;
                        res_next.needs_writeback = 1'b0;
                        res_next.out_device      = dev_reg;
                        res_next.out_block       = blk_reg;
                    end else begin
                        res_next        = '0;
                        res_next.status = ST_NO_FREE;
                    end
                    state_next = S_DONE;
                end
            end

            S_REL_RD: begin
                state_next = S_REL_EV;
            end

            S_REL_EV: begin
                res_next.slot        = idx_reg;
                res_next.needs_fetch = 1'b0;
                res_next.out_device  = rd_entry.tag_device;
                res_next.out_block   = rd_entry.tag_block;
                if (rd_entry.ref_count == 8'd0) begin
                    // count stays at zero
                    res_next.status          = ST_BAD_RELEASE;
                    res_next.needs_writeback = 1'b0;
                end else begin
                    wr_data_next             = rd_entry;
                    wr_data_next.ref_count   = rd_entry.ref_count - 8'd1;
                    wr_addr_next             = IDX_W'(idx_reg);
                    wr_pend_next             = 1'b1;
                    res_next.status          = ST_OK;
                    res_next.needs_writeback = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        // payload, no reset
        kind_reg      <= kind_next;
        dev_reg       <= dev_next;
        blk_reg       <= blk_next;
        idx_reg       <= idx_next;
        tick_reg      <= tick_next;
        issue_cnt_reg <= issue_cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        vic_idx_reg   <= vic_idx_next;
        vic_stamp_reg <= vic_stamp_next;
        wr_addr_reg   <= wr_addr_next;
        wr_data_reg   <= wr_data_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
        // control
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            have_vic_reg  <= 1'b0;
            wr_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            have_vic_reg  <= have_vic_next;
            wr_pend_reg   <= wr_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // an accepted item holds off the next one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on the cycle after an accept");

    // the table is written only together with loading the result beat
    a_write_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_req.wr_en |=> (m_tvalid && (m_res_reg.status != ST_NO_FREE)))
        else $error("table write without a matching result");

    // a failed acquire carries no entry
    a_no_free_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_res_reg.status == ST_NO_FREE)) |->
        ((m_res_reg.slot == 6'd0) && !m_res_reg.needs_fetch &&
         (m_res_reg.out_device == 8'd0) && (m_res_reg.out_block == 32'd0)))
        else $error("no-free result with nonzero fields");

    // fetch and writeback never come together
    a_fetch_xor_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_res_reg.needs_fetch && m_res_reg.needs_writeback))
        else $error("fetch and writeback in the same result");

endmodule

`default_nettype wire

>>> tb/tb_block_buffer_cache_lru_top.sv
// testbench for block_buffer_cache_lru_top: acquire and release beats go in, and each
// result beat is checked against a model of the tag table kept inside the testbench
// depends on bbc_pkg and the rtl of the block buffer cache
module tb_block_buffer_cache_lru_top;
    import bbc_pkg::*;

    localparam int RES_W       = $bits(result_t);
    localparam int KEY_POOL    = 80;          // a bit more keys than entries, so blocks get replaced
    localparam int MAX_CYCLES  = 1_000_000;   // well above the slowest legal run
    localparam int TAIL_CYCLES = 80;          // longer than the acquire latency
    localparam int HOLD_CYCLES = 400;

    // one request as the sender sees it
    typedef struct packed {
        logic        kind;
        logic [7:0]  device;
        logic [31:0] block;
        logic [5:0]  index;
        logic [31:0] tick;
    } cache_req_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    always #5 aclk = ~aclk;

    block_buffer_cache_lru_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // model of the tag table, updated as each request beat is accepted
    logic [7:0]  dev_tbl   [ENTRIES];
    logic [31:0] blk_tbl   [ENTRIES];
    logic [7:0]  cnt_tbl   [ENTRIES];
    logic [31:0] stamp_tbl [ENTRIES];
    logic        valid_tbl [ENTRIES];
    logic        occ_tbl   [ENTRIES];

    // blocks that random acquires keep coming back to
    logic [7:0]  pool_dev [KEY_POOL];
    logic [31:0] pool_blk [KEY_POOL];

    result_t     pending_results[$];
    result_t     last_grant;
    logic [31:0] tick_now   = '0;
    bit          idle_on    = 1'b1;
    bit          hold_off   = 1'b0;
    int          sink_stall = 0;
    int          cycle_count = 0;

    int mismatch_count   = 0;
    int items_sent       = 0;
    int results_checked  = 0;
    int hits             = 0;
    int evictions        = 0;
    int full_refusals    = 0;
    int bad_releases     = 0;

    // expected result of one request; updates the table model
    function automatic result_t cache_predict(cache_req_t r);
        result_t res;
        int      i;
        int      victim;
        res = '0;
        if (r.kind == KIND_RELEASE) begin
            res.status = ST_BAD_RELEASE;
            res.slot   = r.index;
            // index past the table: only the status and the slot are reported
            if (int'(r.index) >= ENTRIES) begin
                bad_releases++;
                return res;
            end
            res.out_device = dev_tbl[r.index];
            res.out_block  = blk_tbl[r.index];
            if (cnt_tbl[r.index] == 8'd0) begin
                bad_releases++;
            end else begin
                cnt_tbl[r.index]    = cnt_tbl[r.index] - 8'd1;
                res.status          = ST_OK;
                res.needs_writeback = 1'b1;
            end
            return res;
        end
        victim = -1;
        for (i = 0; i < ENTRIES; i++) begin
            // a match needs the occupied mark and both tags
            if (occ_tbl[i] && dev_tbl[i] == r.device && blk_tbl[i] == r.block) begin
                res.needs_fetch = ~valid_tbl[i];
                if (cnt_tbl[i] != REF_MAX)
                    cnt_tbl[i] = cnt_tbl[i] + 8'd1;
                stamp_tbl[i]   = r.tick;
                valid_tbl[i]   = 1'b1;
                res.status     = ST_OK;
                res.slot       = i[5:0];
                res.out_device = r.device;
                res.out_block  = r.block;
                hits++;
                return res;
            end
            // oldest unreferenced stamp, plain unsigned compare, lowest index on a tie
            if (cnt_tbl[i] == 8'd0 && (victim < 0 || stamp_tbl[i] < stamp_tbl[victim]))
                victim = i;
        end
        if (victim < 0) begin
            res.status = ST_NO_FREE;
            full_refusals++;
            return res;
        end
        if (occ_tbl[victim])
            evictions++;
        dev_tbl[victim]   = r.device;
        blk_tbl[victim]   = r.block;
        cnt_tbl[victim]   = 8'd1;
        stamp_tbl[victim] = r.tick;
        occ_tbl[victim]   = 1'b1;
        valid_tbl[victim] = 1'b1;
        res.status        = ST_OK;
        res.slot          = victim[5:0];
        res.needs_fetch   = 1'b1;
        res.out_device    = r.device;
        res.out_block     = r.block;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        // keep the log short if the block is badly broken
        if (mismatch_count < 40)
            $display("[%0t] mismatch on %s: got %0h, expected %0h (result beat %0d)",
                     $realtime, what, got, want, results_checked);
        mismatch_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // random request: a release of a mostly referenced entry, or an acquire of a
    // pooled block, now and then a fresh one; unused fields carry random junk
    function automatic cache_req_t pick_item(int release_pct);
        cache_req_t r;
        int         k;
        int         start;
        r.kind   = KIND_ACQUIRE;
        r.device = 8'($urandom());
        r.block  = $urandom();
        r.index  = 6'($urandom());
        if ($urandom_range(0, 15) == 0)
            tick_now = $urandom();
        else
            tick_now = tick_now + $urandom_range(0, 4);   // zero steps give equal stamps
        r.tick = tick_now;
        if ($urandom_range(0, 99) < release_pct) begin
            r.kind = KIND_RELEASE;
            if ($urandom_range(0, 3) != 0) begin
                start = int'(r.index);
                for (k = 0; k < ENTRIES; k++) begin
                    if (cnt_tbl[(start + k) % ENTRIES] != 8'd0) begin
                        r.index = 6'((start + k) % ENTRIES);
                        break;
                    end
                end
            end
        end else if ($urandom_range(0, 9) != 0) begin
            k        = $urandom_range(0, KEY_POOL - 1);
            r.device = pool_dev[k];
            r.block  = pool_blk[k];
        end
        return r;
    endfunction

    // offer one request beat, with a random gap before it while idling is on;
    // tvalid stays high between beats that follow each other directly
    task automatic send_item(cache_req_t r);
        logic [S_DATA_W-1:0] beat;
        beat        = '0;
        beat[7:0]   = r.device;
        beat[39:8]  = r.block;
        beat[45:40] = r.index;
        beat[77:46] = r.tick;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= beat;
        do @(posedge aclk); while (s_tready !== 1'b1);
        last_grant = cache_predict(r);
        pending_results.push_back(last_grant);
        items_sent++;
    endtask

    task automatic acquire(logic [7:0] dev, logic [31:0] blk, logic [31:0] tick);
        cache_req_t r;
        r.kind   = KIND_ACQUIRE;
        r.device = dev;
        r.block  = blk;
        r.index  = 6'($urandom());
        r.tick   = tick;
        send_item(r);
    endtask

    task automatic release_entry(logic [5:0] idx, logic [31:0] tick);
        cache_req_t r;
        r.kind   = KIND_RELEASE;
        r.device = 8'($urandom());
        r.block  = $urandom();
        r.index  = idx;
        r.tick   = tick;
        send_item(r);
    endtask

    // drop tvalid and wait until every expected result beat has been seen
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // extremes, the occupied gate, device-only mismatch, lru ties, release at zero
    task automatic test_directed();
        acquire(8'h00, 32'h0000_0000, 32'h0000_0000);  // zero tags miss on an empty table
        acquire(8'h00, 32'h0000_0000, 32'h0000_0001);  // now a hit on entry 0
        acquire(8'h01, 32'h0000_0000, 32'h0000_0002);  // same block, other device: miss
        acquire(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        release_entry(6'd0, 32'h0000_0003);
        release_entry(6'd0, 32'h0000_0004);
        release_entry(6'd0, 32'h0000_0005);            // count already at zero
        release_entry(6'd63, 32'hFFFF_FFFF);           // never used entry
        acquire(8'h5A, 32'hA5A5_A5A5, 32'h0000_0006);  // tie on stamp zero, lowest index wins
        acquire(8'h00, 32'h0000_0000, 32'h0000_0007);  // hit on an unreferenced entry
        release_entry(6'd2, 32'h8000_0000);
        release_entry(6'd1, 32'h8000_0001);
        acquire(8'hA5, 32'h5A5A_5A5A, 32'h0000_0008);
        acquire(8'hFF, 32'hFFFF_FFFF, 32'h0000_0009);  // hit on a released entry
        release_entry(6'd2, 32'h0000_000A);
        release_entry(6'd3, 32'h0000_000B);
        release_entry(6'd4, 32'h0000_000C);
        release_entry(6'd0, 32'h0000_000D);
        acquire(8'h80, 32'h8000_0001, 32'h7FFF_FFFF);
        release_entry(6'd32, 32'h0000_000E);
        drain_results();
    endtask

    // reference every entry, then ask for one more block
    task automatic test_table_full();
        int i;
        int guard;
        bit free_left;
        guard = 0;
        do begin
            tick_now = tick_now + 1;
            acquire(8'($urandom_range(0, 255)), $urandom(), tick_now);
            free_left = 1'b0;
            for (i = 0; i < ENTRIES; i++)
                if (cnt_tbl[i] == 8'd0)
                    free_left = 1'b1;
            guard++;
        end while (free_left && guard < 4 * ENTRIES);
        acquire(8'($urandom_range(0, 255)), $urandom(), tick_now);   // refused
        acquire(dev_tbl[ENTRIES / 2], blk_tbl[ENTRIES / 2], tick_now); // hits still work
        for (i = 0; i < ENTRIES; i++)
            while (cnt_tbl[i] != 8'd0)
                release_entry(i[5:0], tick_now);
        release_entry(6'($urandom()), tick_now);
        drain_results();
    endtask

    // acquire one block 258 times so its count saturates at 255, then release it all the way down and once more
    task automatic test_saturation();
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [5:0]  slot;
        int          n;
        dev = 8'($urandom());
        blk = $urandom();
        for (n = 0; n < 258; n++) begin
            tick_now = tick_now + 1;
            acquire(dev, blk, tick_now);
        end
        slot = last_grant.slot;
        while (cnt_tbl[slot] != 8'd0)
            release_entry(slot, tick_now);
        release_entry(slot, tick_now);
        drain_results();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_receiver_hold();
        int n;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
            for (n = 0; n < 8; n++)
                send_item(pick_item(40));
        join
        drain_results();
    endtask

    // bulk of the run: chunks with different release rates, so the table swings
    // between nearly empty and full
    task automatic test_random_mix(int chunks, int per_chunk);
        int c;
        int n;
        int pct;
        for (c = 0; c < chunks; c++) begin
            case ($urandom_range(0, 2))
                0:       pct = 20;
                1:       pct = 45;
                default: pct = 70;
            endcase
            for (n = 0; n < per_chunk; n++)
                send_item(pick_item(pct));
        end
        drain_results();
    endtask

    // last part: no idling on either side
    task automatic test_back_to_back(int count);
        int n;
        idle_on = 1'b0;
        for (n = 0; n < count; n++)
            send_item(pick_item(45));
        drain_results();
    endtask

    // result side: random stall bursts, plus the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else if (hold_off) begin
            m_tready <= 1'b0;
        end else if (sink_stall != 0) begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            sink_stall <= $urandom_range(0, 17);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare every accepted result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected", m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(got.status), 32'(want.status));
                check_field("slot", 32'(got.slot), 32'(want.slot));
                check_field("needs_fetch", 32'(got.needs_fetch), 32'(want.needs_fetch));
                check_field("needs_writeback", 32'(got.needs_writeback),
                            32'(want.needs_writeback));
                check_field("out_device", 32'(got.out_device), 32'(want.out_device));
                check_field("out_block", got.out_block, want.out_block);
                check_field("zero pad", 32'(m_tdata[M_DATA_W-1:RES_W]), '0);
            end
            results_checked++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d result beats still outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int k;
        foreach (dev_tbl[i]) begin
            dev_tbl[i]   = '0;
            blk_tbl[i]   = '0;
            cnt_tbl[i]   = '0;
            stamp_tbl[i] = '0;
            valid_tbl[i] = 1'b0;
            occ_tbl[i]   = 1'b0;
        end
        // every fourth pooled key shares a block number with its neighbor
        // but sits on another device
        for (k = 0; k < KEY_POOL; k++) begin
            if (k % 4 == 3) begin
                pool_blk[k] = pool_blk[k - 1];
                pool_dev[k] = pool_dev[k - 1] ^ (8'd1 << $urandom_range(0, 7));
            end else begin
                pool_blk[k] = $urandom();
                pool_dev[k] = 8'($urandom());
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_table_full();
        test_saturation();
        test_receiver_hold();
        test_random_mix(14, 80);
        test_back_to_back(150);

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d requests, %0d result beats: %0d hits, %0d cached blocks replaced",
                 items_sent, results_checked, hits, evictions);
        $display("%0d acquires refused on a full table, %0d releases of unreferenced entries",
                 full_refusals, bad_releases);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/bbc_pkg.sv
sv/bbc_table.sv
sv/bbc_cmp.sv
sv/block_buffer_cache_lru_top.sv
tb/tb_block_buffer_cache_lru_top.sv
